@@ src/fisher_yates_list_shuffle_defines.svh @@
// Assertion macros for the list shuffle block.
// Expect clk and arst_n in the scope of each use.
`ifndef FISHER_YATES_LIST_SHUFFLE_DEFINES_SVH
`define FISHER_YATES_LIST_SHUFFLE_DEFINES_SVH

// same-cycle implication
`define FYS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FYS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fys_pkg.sv @@
// Shared types and constants for the list shuffle block.
// No dependencies.
package fys_pkg;

	localparam int VALUE_W = 32;
	localparam int DRAW_W  = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_DRAW,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_PICK,
		ST_PICK_CAP,
		ST_SH_RD,
		ST_SH_WR,
		ST_PUT,
		ST_OUT_RD,
		ST_OUT_EMIT
	} fys_state_t;

endpackage

@@ src/fys_mod.sv @@
// Bit-serial remainder unit: one restoring step per cycle over the draw.
// Depends on fys_pkg.
module fys_mod #(
	parameter int DIVW = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fys_pkg::DRAW_W-1:0] dividend,
	input  logic [DIVW-1:0]          divisor,
	output logic                     done,
	output logic [DIVW-1:0]          remainder
);

	localparam int CNTW = $clog2(fys_pkg::DRAW_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNTW-1:0]             cnt_q;
	logic [fys_pkg::DRAW_W-1:0]  dvd_q;
	logic [DIVW-1:0]             dsr_q;
	logic [DIVW-1:0]             rem_q;
	logic [DIVW:0]               trial;
	logic [DIVW:0]               diff;

	assign trial = {rem_q, dvd_q[fys_pkg::DRAW_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(fys_pkg::DRAW_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fys_pkg::DRAW_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				rem_q <= diff[DIVW-1:0];
			else
				rem_q <= trial[DIVW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ src/fisher_yates_list_shuffle.sv @@
// Top level of the list shuffle block: load, in-place shuffle, read-out.
// Depends on fys_pkg, fys_mod and fisher_yates_list_shuffle_defines.svh.
//
//  channel   signals                                   transfer
//  input     start, busy, item_value, random_draw,     start high and busy low
//            is_last
//  result    result_valid, out_value, out_last         result_valid high, one cycle
//
// Loading accepts one item per cycle. The last item (or the one that fills the store)
// starts n shuffle steps; each step runs its draw through the bit-serial remainder unit,
// then shifts the later items down through the value memory, one read and one write each.
// Read-out then gives the results in stored order; busy stays high until the final one.
// Reset clears the sequencer, the item count and the remainder unit's control only. Results cannot be stalled.
`include "fisher_yates_list_shuffle_defines.svh"

module fisher_yates_list_shuffle #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [fys_pkg::VALUE_W-1:0] item_value,
	input  logic [fys_pkg::DRAW_W-1:0]        random_draw,
	input  logic                              is_last,
	output logic                              result_valid,
	output logic signed [fys_pkg::VALUE_W-1:0] out_value,
	output logic                              out_last
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	logic [fys_pkg::VALUE_W-1:0] value_mem [MAX_ITEMS];
	logic [fys_pkg::DRAW_W-1:0]  draw_mem  [MAX_ITEMS];

	fys_pkg::fys_state_t state_q, state_d;

	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               n_q;
	logic [AW-1:0]               t_q;
	logic [AW-1:0]               i_q;
	logic [AW-1:0]               o_q;
	logic [fys_pkg::VALUE_W-1:0] picked_q;
	logic [fys_pkg::VALUE_W-1:0] val_rd_q;
	logic [fys_pkg::DRAW_W-1:0]  draw_rd_q;

	logic                        val_we;
	logic [AW-1:0]               val_wa;
	logic [fys_pkg::VALUE_W-1:0] val_wd;
	logic [AW-1:0]               val_ra;
	logic                        accept;
	logic                        end_load;
	logic                        mod_start;
	logic                        mod_done;
	logic [CW-1:0]               mod_rem;
	logic [CW-1:0]               left;

	assign accept   = start && !busy;
	assign end_load = is_last || (cnt_q + 1'b1 == CW'(MAX_ITEMS));
	assign left     = n_q - CW'(t_q);

	fys_mod #(
		.DIVW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (draw_rd_q),
		.divisor  (left),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fys_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		val_we    = 1'b0;
		val_wa    = i_q;
		val_wd    = val_rd_q;
		val_ra    = i_q;
		mod_start = 1'b0;
		case (state_q)
			fys_pkg::ST_IDLE: begin
				val_wa = cnt_q[AW-1:0];
				val_wd = item_value;
				if (accept) begin
					val_we = 1'b1;
					if (end_load)
						state_d = fys_pkg::ST_RD_DRAW;
				end
			end
			fys_pkg::ST_RD_DRAW:   state_d = fys_pkg::ST_DIV_START;
			fys_pkg::ST_DIV_START: begin
				mod_start = 1'b1;
				state_d   = fys_pkg::ST_DIV_WAIT;
			end
			fys_pkg::ST_DIV_WAIT: begin
				if (mod_done)
					state_d = fys_pkg::ST_PICK;
			end
			fys_pkg::ST_PICK:      state_d = fys_pkg::ST_PICK_CAP;
			fys_pkg::ST_PICK_CAP: begin
				if (CW'(i_q) + 1'b1 < n_q)
					state_d = fys_pkg::ST_SH_RD;
				else
					state_d = fys_pkg::ST_PUT;
			end
			fys_pkg::ST_SH_RD: begin
				val_ra  = i_q + 1'b1;
				state_d = fys_pkg::ST_SH_WR;
			end
			fys_pkg::ST_SH_WR: begin
				val_we = 1'b1;
				if (CW'(i_q) + 2'd2 < n_q)
					state_d = fys_pkg::ST_SH_RD;
				else
					state_d = fys_pkg::ST_PUT;
			end
			fys_pkg::ST_PUT: begin
				val_we = 1'b1;
				val_wa = AW'(n_q - 1'b1);
				val_wd = picked_q;
				if (CW'(t_q) + 1'b1 == n_q)
					state_d = fys_pkg::ST_OUT_RD;
				else
					state_d = fys_pkg::ST_RD_DRAW;
			end
			fys_pkg::ST_OUT_RD: begin
				val_ra  = o_q;
				state_d = fys_pkg::ST_OUT_EMIT;
			end
			fys_pkg::ST_OUT_EMIT: begin
				if (CW'(o_q) + 1'b1 == n_q)
					state_d = fys_pkg::ST_IDLE;
				else
					state_d = fys_pkg::ST_OUT_RD;
			end
			default: state_d = fys_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == fys_pkg::ST_IDLE && accept) begin
			cnt_q <= end_load ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fys_pkg::ST_IDLE: begin
				if (accept) begin
					n_q <= cnt_q + 1'b1;
					t_q <= '0;
				end
			end
			fys_pkg::ST_DIV_WAIT: begin
				if (mod_done)
					i_q <= mod_rem[AW-1:0];
			end
			fys_pkg::ST_PICK_CAP: picked_q <= val_rd_q;
			fys_pkg::ST_SH_WR:    i_q <= i_q + 1'b1;
			fys_pkg::ST_PUT: begin
				t_q <= t_q + 1'b1;
				o_q <= '0;
			end
			fys_pkg::ST_OUT_EMIT: o_q <= o_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we)
			value_mem[val_wa] <= val_wd;
		val_rd_q <= value_mem[val_ra];
	end

	always_ff @(posedge clk) begin
		if (accept)
			draw_mem[cnt_q[AW-1:0]] <= random_draw;
		draw_rd_q <= draw_mem[t_q];
	end

	assign busy         = (state_q != fys_pkg::ST_IDLE);
	assign result_valid = (state_q == fys_pkg::ST_OUT_EMIT);
	assign out_value    = val_rd_q;
	assign out_last     = result_valid && (CW'(o_q) + 1'b1 == n_q);

	`FYS_ASSERT_NOW(a_result_while_busy, result_valid, busy, "result outside busy window")
	`FYS_ASSERT_NEXT(a_last_releases, result_valid && out_last, !busy, "busy held after final result")
	`FYS_ASSERT_NOW(a_step_in_range, state_q == fys_pkg::ST_PUT, CW'(t_q) < n_q, "shuffle step beyond count")
	`FYS_ASSERT_NOW(a_shift_in_range, state_q == fys_pkg::ST_SH_WR, CW'(i_q) + 1'b1 < n_q, "shift beyond count")

endmodule
